// ===== src/pc_pkg.sv =====
package pc_pkg;

  localparam int MAX_CLIP_DEF  = 32;
  localparam int MAX_VERTS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam int COORD_W = 32;
  localparam int VTX_W   = 2 * COORD_W;

  // Input command codes.
  localparam logic [1:0] CMD_LOAD_CLIP = 2'd0;
  localparam logic [1:0] CMD_LOAD_SUBJ = 2'd1;
  localparam logic [1:0] CMD_RUN       = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_VALID    = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    MUL_IN1, MUL_IN2, MUL_DEN1, MUL_DEN2, MUL_NUM1, MUL_NUM2, MUL_X, MUL_Y
  } mul_sel_t;

  typedef enum logic [1:0] {
    RA_LAST, RA_ZERO, RA_NEXT, RA_OUT
  } src_addr_t;

  typedef struct packed {
    logic      load_clip;
    logic      load_subj;
    logic      run_start;
    logic      clip_rd;
    logic      clip_rd_next;
    logic      latch_a;
    logic      latch_b;
    logic      src_rd;
    src_addr_t src_sel;
    logic      latch_e;
    logic      mul_en;
    mul_sel_t  mul_sel;
    logic      ins_cap;
    logic      den_cap;
    logic      num_cap;
    logic      div_init;
    logic      div_step;
    logic      push_x;
    logic      push_e;
    logic      adv_s;
    logic      pass_end;
    logic      out_load;
    logic      out_empty;
    logic      run_clear;
  } pc_cmd_t;

  typedef struct packed {
    logic pass_go;
    logic n_zero;
    logic ein;
    logic sin;
    logic div_done;
    logic i_last;
    logic k_last;
    logic out_free;
  } pc_stat_t;

endpackage

// ===== src/pc_ram.sv =====
module pc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/pc_datapath.sv =====
module pc_datapath #(
  parameter int MAX_CLIP  = pc_pkg::MAX_CLIP_DEF,
  parameter int MAX_VERTS = pc_pkg::MAX_VERTS_DEF,
  parameter int FRAC_BITS = pc_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pc_pkg::pc_cmd_t      cmd,
  output pc_pkg::pc_stat_t     stat,
  input  logic signed [31:0]   coord_x,
  input  logic signed [31:0]   coord_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_x,
  output logic signed [31:0]   out_y,
  output logic                 last_vertex,
  output logic [1:0]           status
);
  import pc_pkg::*;

  localparam int CA_W = $clog2(MAX_CLIP);
  localparam int CC_W = $clog2(MAX_CLIP + 1);
  localparam int VA_W = $clog2(MAX_VERTS);
  localparam int VC_W = $clog2(MAX_VERTS + 1);
  localparam int T_W  = FRAC_BITS + 1;
  localparam int DC_W = (FRAC_BITS > 0) ? $clog2(FRAC_BITS + 1) : 1;

  localparam logic [CC_W-1:0] CLIP_CAP = CC_W'(MAX_CLIP);
  localparam logic [VC_W-1:0] VERT_CAP = VC_W'(MAX_VERTS);
  localparam logic [T_W-1:0]  T_ONE    = T_W'(1 << FRAC_BITS);
  localparam logic [DC_W-1:0] DIV_LEN  = DC_W'(FRAC_BITS);

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] d;
    d = {a[63], a} - {b[63], b};
    if (d[64] != d[63]) begin
      sat_sub = d[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_sub = d[63:0];
    end
  endfunction

  // Counters and flags.
  logic [CC_W-1:0] cc, j;
  logic [VC_W-1:0] sc, n, m;
  logic [VA_W-1:0] i, k;
  logic            cur, ovf;

  // Edge and vertex registers.
  logic signed [31:0] ax, ay, bx, by, sx, sy, ex, ey;
  logic               ein, sin;

  // Arithmetic registers.
  logic signed [63:0] p, p1, den, num;
  logic [63:0]        rem, ud;
  logic [T_W-1:0]     t;
  logic [DC_W-1:0]    dcnt;

  // Memory ports.
  logic [VTX_W-1:0] clip_rdata, b0_rdata, b1_rdata, rd_vtx, push_data;
  logic [CC_W-1:0]  j_nx, clip_idx;
  logic [VC_W-1:0]  n_m1, i_p1;
  logic [VA_W-1:0]  src_addr, b0_waddr;
  logic             b0_we, b1_we, push, push_ok, clip_room, subj_room;

  // Multiplier and divider signals.
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod, p_sh, p1_sh, diff;
  logic [63:0]        un_c, ud_c;
  logic [64:0]        rem2, rem_sub;
  logic               divide, ge;

  assign n_m1      = n - 1'b1;
  assign i_p1      = VC_W'(i) + 1'b1;
  assign j_nx      = j + 1'b1;
  assign clip_idx  = cmd.clip_rd_next ? ((j_nx == cc) ? '0 : j_nx) : j;
  assign clip_room = cc < CLIP_CAP;
  assign subj_room = sc < VERT_CAP;
  assign push      = cmd.push_x || cmd.push_e;
  assign push_ok   = m < VERT_CAP;

  always_comb begin
    case (cmd.src_sel)
      RA_LAST: src_addr = n_m1[VA_W-1:0];
      RA_ZERO: src_addr = '0;
      RA_NEXT: src_addr = i_p1[VA_W-1:0];
      default: src_addr = k;
    endcase
  end

  assign rd_vtx   = cur ? b1_rdata : b0_rdata;
  assign p_sh     = p >>> FRAC_BITS;
  assign p1_sh    = p1 >>> FRAC_BITS;
  assign diff     = sat_sub(p1_sh, p_sh);
  assign push_data = cmd.push_x ? {sx + p1_sh[31:0], sy + p_sh[31:0]} : {ex, ey};

  assign b0_we    = (cmd.load_subj && subj_room) || (push && push_ok && cur);
  assign b1_we    = push && push_ok && !cur;
  assign b0_waddr = cmd.load_subj ? sc[VA_W-1:0] : m[VA_W-1:0];

  pc_ram #(.WIDTH(VTX_W), .DEPTH(MAX_CLIP)) u_clip (
    .clk(clk), .we(cmd.load_clip && clip_room), .waddr(cc[CA_W-1:0]),
    .wdata({coord_x, coord_y}), .re(cmd.clip_rd), .raddr(clip_idx[CA_W-1:0]),
    .rdata(clip_rdata)
  );

  pc_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTS)) u_bank0 (
    .clk(clk), .we(b0_we), .waddr(b0_waddr),
    .wdata(cmd.load_subj ? {coord_x, coord_y} : push_data),
    .re(cmd.src_rd), .raddr(src_addr), .rdata(b0_rdata)
  );

  pc_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTS)) u_bank1 (
    .clk(clk), .we(b1_we), .waddr(m[VA_W-1:0]), .wdata(push_data),
    .re(cmd.src_rd), .raddr(src_addr), .rdata(b1_rdata)
  );

  // Shared 32x32 signed multiplier operand selection.
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_IN1:  begin op_a = bx - ax; op_b = ey - ay; end
      MUL_IN2:  begin op_a = by - ay; op_b = ex - ax; end
      MUL_DEN1: begin op_a = sx - ex; op_b = ay - by; end
      MUL_DEN2: begin op_a = sy - ey; op_b = ax - bx; end
      MUL_NUM1: begin op_a = sx - ax; op_b = ay - by; end
      MUL_NUM2: begin op_a = sy - ay; op_b = ax - bx; end
      MUL_X:    begin op_a = ex - sx; op_b = $signed({{(32-T_W){1'b0}}, t}); end
      MUL_Y:    begin op_a = ey - sy; op_b = $signed({{(32-T_W){1'b0}}, t}); end
      default:  begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prod = op_a * op_b;

  // Fraction t = num / den, one quotient bit per step.
  assign un_c   = num[63] ? (~num + 64'd1) : num;
  assign ud_c   = den[63] ? (~den + 64'd1) : den;
  assign divide = (num != '0) && (den != '0) && (num[63] == den[63]);
  assign rem2   = {rem, 1'b0};
  assign ge     = rem2 >= {1'b0, ud};
  assign rem_sub = rem2 - {1'b0, ud};

  always_ff @(posedge clk) begin
    if (rst) begin
      cc        <= '0;
      sc        <= '0;
      ovf       <= 1'b0;
      cur       <= 1'b0;
      j         <= '0;
      n         <= '0;
      m         <= '0;
      i         <= '0;
      k         <= '0;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_clip) begin
        if (clip_room) cc <= cc + 1'b1;
        else ovf <= 1'b1;
      end
      if (cmd.load_subj) begin
        if (subj_room) sc <= sc + 1'b1;
        else ovf <= 1'b1;
      end
      if (cmd.run_start) begin
        n   <= sc;
        cur <= 1'b0;
        j   <= '0;
        k   <= '0;
      end
      if (cmd.latch_b) m <= '0;
      if (cmd.src_rd && cmd.src_sel == RA_ZERO) i <= '0;
      if (cmd.src_rd && cmd.src_sel == RA_NEXT) i <= i_p1[VA_W-1:0];
      if (push) begin
        if (push_ok) m <= m + 1'b1;
        else ovf <= 1'b1;
      end
      if (cmd.pass_end) begin
        n   <= m;
        cur <= ~cur;
        j   <= j_nx;
      end
      if (cmd.div_init) begin
        dcnt <= (divide && un_c < ud_c) ? DIV_LEN : '0;
      end else if (cmd.div_step && dcnt != '0) begin
        dcnt <= dcnt - 1'b1;
      end
      if (cmd.out_load) k <= k + 1'b1;
      if (cmd.out_load || cmd.out_empty) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.run_clear) begin
        cc  <= '0;
        sc  <= '0;
        ovf <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_a) begin
      ax <= clip_rdata[63:32];
      ay <= clip_rdata[31:0];
    end
    if (cmd.latch_b) begin
      bx <= clip_rdata[63:32];
      by <= clip_rdata[31:0];
    end
    if (cmd.latch_e) begin
      ex <= rd_vtx[63:32];
      ey <= rd_vtx[31:0];
    end
    if (cmd.adv_s) begin
      sx  <= ex;
      sy  <= ey;
      sin <= ein;
    end
    if (cmd.mul_en) begin
      p  <= prod;
      p1 <= p;
    end
    if (cmd.ins_cap) ein <= p1 >= p;
    if (cmd.den_cap) den <= diff;
    if (cmd.num_cap) num <= diff;
    if (cmd.div_init) begin
      t <= '0;
      if (divide) begin
        if (un_c >= ud_c) begin
          t <= T_ONE;
        end else begin
          rem <= un_c;
          ud  <= ud_c;
        end
      end
    end else if (cmd.div_step && dcnt != '0) begin
      rem <= ge ? rem_sub[63:0] : rem2[63:0];
      t   <= (t << 1) | T_W'(ge);
    end
    if (cmd.out_load) begin
      out_x       <= rd_vtx[63:32];
      out_y       <= rd_vtx[31:0];
      last_vertex <= VC_W'(k) == n_m1;
      status      <= ovf ? STAT_OVERFLOW : STAT_VALID;
    end else if (cmd.out_empty) begin
      out_x       <= '0;
      out_y       <= '0;
      last_vertex <= 1'b1;
      status      <= ovf ? STAT_OVERFLOW : STAT_EMPTY;
    end
  end

  assign stat.pass_go  = (j < cc) && (n != '0);
  assign stat.n_zero   = n == '0;
  assign stat.ein      = ein;
  assign stat.sin      = sin;
  assign stat.div_done = dcnt == '0;
  assign stat.i_last   = VC_W'(i) == n_m1;
  assign stat.k_last   = VC_W'(k) == n_m1;
  assign stat.out_free = !out_valid || out_ready;

`ifndef ASSERT_OFF
  a_push_full_sets_ovf: assert property (@(posedge clk) disable iff (rst)
    push && !push_ok |=> ovf)
    else $error("dropped vertex did not raise overflow");

  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load || cmd.out_empty) |-> (!out_valid || out_ready))
    else $error("result loaded over a waiting beat");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    cmd.run_start |=> (cur == 1'b0) && (n == $past(sc)))
    else $error("run did not start from the subject bank");
`endif

endmodule

// ===== src/pc_ctrl.sv =====
module pc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       command,
  input  pc_pkg::pc_stat_t stat,
  output pc_pkg::pc_cmd_t  cmd
);
  import pc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_PASS_CHK, S_RD_A, S_RD_B, S_RD_E, S_IN1, S_IN2, S_INC, S_EVAL,
    S_D1, S_D2, S_N1, S_N2, S_NC, S_DIVI, S_DIV, S_MX, S_MY, S_PUSHX, S_PUSHE,
    S_NEXT, S_OUT_RD, S_OUT_LD, S_OUT_EMPTY
  } state_t;

  state_t state, state_next;
  logic   prime, prime_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    prime_next = prime;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (command)
            CMD_LOAD_CLIP: cmd.load_clip = 1'b1;
            CMD_LOAD_SUBJ: cmd.load_subj = 1'b1;
            CMD_RUN: begin
              cmd.run_start = 1'b1;
              state_next    = S_PASS_CHK;
            end
            default: ;
          endcase
        end
      end
      S_PASS_CHK: begin
        if (stat.pass_go) begin
          cmd.clip_rd = 1'b1;
          state_next  = S_RD_A;
        end else if (stat.n_zero) begin
          state_next = S_OUT_EMPTY;
        end else begin
          state_next = S_OUT_RD;
        end
      end
      S_RD_A: begin
        cmd.latch_a      = 1'b1;
        cmd.clip_rd      = 1'b1;
        cmd.clip_rd_next = 1'b1;
        state_next       = S_RD_B;
      end
      S_RD_B: begin
        cmd.latch_b = 1'b1;
        cmd.src_rd  = 1'b1;
        cmd.src_sel = RA_LAST;
        prime_next  = 1'b1;
        state_next  = S_RD_E;
      end
      S_RD_E: begin
        cmd.latch_e = 1'b1;
        state_next  = S_IN1;
      end
      S_IN1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_IN1;
        state_next  = S_IN2;
      end
      S_IN2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_IN2;
        state_next  = S_INC;
      end
      S_INC: begin
        cmd.ins_cap = 1'b1;
        state_next  = S_EVAL;
      end
      S_EVAL: begin
        if (prime) begin
          cmd.adv_s   = 1'b1;
          cmd.src_rd  = 1'b1;
          cmd.src_sel = RA_ZERO;
          prime_next  = 1'b0;
          state_next  = S_RD_E;
        end else if (stat.ein != stat.sin) begin
          state_next = S_D1;
        end else if (stat.ein) begin
          state_next = S_PUSHE;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_D1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DEN1;
        state_next  = S_D2;
      end
      S_D2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DEN2;
        state_next  = S_N1;
      end
      S_N1: begin
        cmd.den_cap = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_NUM1;
        state_next  = S_N2;
      end
      S_N2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_NUM2;
        state_next  = S_NC;
      end
      S_NC: begin
        cmd.num_cap = 1'b1;
        state_next  = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_MX;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_MX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_X;
        state_next  = S_MY;
      end
      S_MY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Y;
        state_next  = S_PUSHX;
      end
      S_PUSHX: begin
        cmd.push_x = 1'b1;
        state_next = stat.ein ? S_PUSHE : S_NEXT;
      end
      S_PUSHE: begin
        cmd.push_e = 1'b1;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        cmd.adv_s = 1'b1;
        if (stat.i_last) begin
          cmd.pass_end = 1'b1;
          state_next   = S_PASS_CHK;
        end else begin
          cmd.src_rd  = 1'b1;
          cmd.src_sel = RA_NEXT;
          state_next  = S_RD_E;
        end
      end
      S_OUT_RD: begin
        cmd.src_rd  = 1'b1;
        cmd.src_sel = RA_OUT;
        state_next  = S_OUT_LD;
      end
      S_OUT_LD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.k_last) begin
            cmd.run_clear = 1'b1;
            state_next    = S_IDLE;
          end else begin
            state_next = S_OUT_RD;
          end
        end
      end
      S_OUT_EMPTY: begin
        if (stat.out_free) begin
          cmd.out_empty = 1'b1;
          cmd.run_clear = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      prime <= 1'b0;
    end else begin
      state <= state_next;
      prime <= prime_next;
    end
  end

endmodule

// ===== src/polygon_clipper_unit.sv =====
// Sutherland-Hodgman polygon clipper.
// Input channel (in_valid/in_ready): each beat carries a command and one
// vertex. Command load-clip and load-subject store the vertex and are taken
// one per cycle; excess vertices are dropped and flagged as overflow.
// Command run clips the stored subject against every clip edge in turn and
// then streams the resulting polygon on the output channel
// (out_valid/out_ready), last_vertex marking the final beat. An empty result
// gives one beat with zero coordinates and status empty. Status reads
// overflow on every beat when any vertex was dropped since the last run.
// Each clip edge first fetches the edge and the closing vertex; each subject
// vertex is then read and tested with two products, a kept vertex adds a
// push, and an edge crossing adds the denominator and numerator products,
// the bit-serial divider (skipped when t needs no division) and the two
// products for the intersection point, all on the single shared multiplier.
// Results leave via the vertex store's registered read port; in_ready is low
// for the whole run. When the receiver stalls, the controller waits with
// the next result and holds the current beat in the output register.
// Reset empties both vertex lists and clears the overflow flag and the
// output valid flag; the block is ready as soon as reset is released.
module polygon_clipper_unit #(
  parameter int MAX_CLIP  = pc_pkg::MAX_CLIP_DEF,
  parameter int MAX_VERTS = pc_pkg::MAX_VERTS_DEF,
  parameter int FRAC_BITS = pc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic               last_vertex,
  output logic [1:0]         status
);
  import pc_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  pc_cmd_t  cmd;
  pc_stat_t stat;

  pc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .stat     (stat),
    .cmd      (cmd)
  );

  pc_datapath #(
    .MAX_CLIP  (MAX_CLIP),
    .MAX_VERTS (MAX_VERTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x       (out_x),
    .out_y       (out_y),
    .last_vertex (last_vertex),
    .status      (status)
  );

endmodule
